FILE: hdl/imu_offset_pi_calibrator_macros.svh
// ----------------------------------------------------------------------------
// IMU offset calibrator assertion macros
// Shared concurrent assertion forms for the calibrator pipeline.
// ----------------------------------------------------------------------------
`ifndef IMU_OFFSET_PI_CALIBRATOR_MACROS_SVH
`define IMU_OFFSET_PI_CALIBRATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define IOC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define IOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ioc_pkg.sv
// ----------------------------------------------------------------------------
// IMU offset calibrator package
// Payload types, register indexes, fixed-point widths and the rounding helper.
// ----------------------------------------------------------------------------
package ioc_pkg;

  // Fixed-point widths
  localparam int GAIN_W  = 24;
  localparam int ARG_W   = 17;
  localparam int PROD_W  = GAIN_W + 1 + ARG_W;
  localparam int INTEG_W = 48;
  localparam int SUM_W   = INTEG_W + 1;
  localparam int ESUM_W  = 17;

  localparam int SHIFT_ACCEL = 27;
  localparam int SHIFT_GYRO  = 26;

  localparam logic [SUM_W:0] ROUND_HALF_ACCEL = (SUM_W + 1)'(1) << (SHIFT_ACCEL - 1);
  localparam logic [SUM_W:0] ROUND_HALF_GYRO  = (SUM_W + 1)'(1) << (SHIFT_GYRO - 1);

  // Operation and sensor codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_SAMPLE  = 1'b1;
  localparam logic KIND_ACCEL = 1'b0;
  localparam logic KIND_GYRO  = 1'b1;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_KIND    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROP_GAIN      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INT_GAIN       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRAVITY_COUNTS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_COUNT    = 3'd4;

  localparam logic              RST_SENSOR_KIND    = KIND_ACCEL;
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN      = 24'd5033165;
  localparam logic [GAIN_W-1:0] RST_INT_GAIN       = 24'd335544;
  localparam logic [14:0]       RST_GRAVITY_COUNTS = 15'd16384;
  localparam logic [7:0]        RST_ROUND_COUNT    = 8'd6;

  // Error-sum thresholds
  localparam logic [ESUM_W-1:0] ESUM_GOOD_ACCEL = 17'd100;
  localparam logic [ESUM_W-1:0] ESUM_GOOD_GYRO  = 17'd5;
  localparam logic [ESUM_W-1:0] ESUM_EARLY      = 17'd100;
  localparam logic [ESUM_W-1:0] ESUM_RESTART    = 17'd1000;
  localparam logic [7:0]        GOOD_MIN        = 8'd10;
  localparam logic [7:0]        GOOD_MAX        = 8'd255;
  localparam int                ITER_EARLY_MIN  = 10;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic signed [15:0] value_z;
  } ioc_in_t;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic [17:0]        error_sum;
    logic               round_end;
    logic               finished;
    logic [7:0]         round_number;
    logic               last;
  } ioc_out_t;

  // Per-item control carried alongside the datapath
  typedef struct packed {
    logic              round_end;
    logic              finished;
    logic [7:0]        round_number;
    logic [ESUM_W-1:0] error_sum;
  } ioc_tag_t;

  // Pipeline control handed to each axis lane
  typedef struct packed {
    logic en;
    logic kind;
    logic s2_valid;
    logic s2_start;
  } ioc_pipe_t;

  // Divide by 2^k rounding half away from zero, then saturate to 16 bits.
  function automatic logic signed [15:0] round_sat(input logic [SUM_W-1:0] v,
                                                   input logic kind);
    logic [SUM_W:0]        t_u;
    logic signed [SUM_W:0] t;
    logic signed [23:0]    r;
    logic signed [15:0]    res;
    t_u = {v[SUM_W-1], v} + (kind == KIND_GYRO ? ROUND_HALF_GYRO : ROUND_HALF_ACCEL)
          - {{SUM_W{1'b0}}, v[SUM_W-1]};
    t = $signed(t_u);
    if (kind == KIND_GYRO) begin
      r = 24'(t >>> SHIFT_GYRO);
    end else begin
      r = 24'(t >>> SHIFT_ACCEL);
    end
    if (r > 24'sd32767) begin
      res = 16'sh7FFF;
    end else if (r < -24'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

endpackage

FILE: hdl/ioc_stream_if.sv
// ----------------------------------------------------------------------------
// IMU offset calibrator stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ioc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/ioc_axis.sv
// ----------------------------------------------------------------------------
// IMU offset calibrator axis lane
// P and I products, saturating integral, rounding to the 16-bit offsets.
// ----------------------------------------------------------------------------
module ioc_axis import ioc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ioc_pipe_t                pipe_i,
  input  logic signed [ARG_W-1:0]  arg_i,
  input  logic [GAIN_W-1:0]        pgain_i,
  input  logic [GAIN_W-1:0]        igain_i,
  output logic signed [15:0]       offset_o,
  output logic signed [15:0]       offset_int_o
);

  logic signed [PROD_W-1:0] pp_d, ip_d;
  logic signed [PROD_W-1:0] pp_q, ip_q;
  logic signed [ARG_W-1:0]  arg2_q;
  logic [INTEG_W-1:0]       integ_d, integ_q;
  logic [INTEG_W:0]         integ_acc;
  logic [INTEG_W-1:0]       integ_sat, integ_preset;
  logic                     saved_q;
  logic [PROD_W-1:0]        pp3_q;
  logic [INTEG_W-1:0]       integ3_q;
  logic                     bit3_q;
  logic [SUM_W-1:0]         total4_d, total4_q;
  logic [INTEG_W-1:0]       integ4_q;
  logic                     bit4_q;
  logic signed [15:0]       rnd_total, rnd_integ;

  // Stage 1: products against the item's own gains
  assign pp_d = $signed({1'b0, pgain_i}) * arg_i;
  assign ip_d = $signed({1'b0, igain_i}) * arg_i;

  // Stage 2: integral update or preset
  assign integ_acc = {integ_q[INTEG_W-1], integ_q}
                   + {{(INTEG_W + 1 - PROD_W){ip_q[PROD_W-1]}}, ip_q};

  always_comb begin
    if (integ_acc[INTEG_W] != integ_acc[INTEG_W-1]) begin
      integ_sat = integ_acc[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = integ_acc[INTEG_W-1:0];
    end
  end

  always_comb begin
    if (pipe_i.kind == KIND_GYRO) begin
      integ_preset = {{(INTEG_W - ARG_W - SHIFT_GYRO){arg2_q[ARG_W-1]}}, arg2_q,
                      {SHIFT_GYRO{1'b0}}};
    end else begin
      integ_preset = {{(INTEG_W - ARG_W - SHIFT_ACCEL){arg2_q[ARG_W-1]}}, arg2_q,
                      {SHIFT_ACCEL{1'b0}}};
    end
  end

  assign integ_d = pipe_i.s2_start ? integ_preset : integ_sat;

  // Stage 3: P plus I
  assign total4_d = {{(SUM_W - PROD_W){pp3_q[PROD_W-1]}}, pp3_q}
                  + {integ3_q[INTEG_W-1], integ3_q};

  // Stage 4: round, saturate, restore bit zero on the accelerometer
  assign rnd_total = round_sat(total4_q, pipe_i.kind);
  assign rnd_integ = round_sat({integ4_q[INTEG_W-1], integ4_q}, pipe_i.kind);

  assign offset_o     = (pipe_i.kind == KIND_ACCEL) ? {rnd_total[15:1], bit4_q} : rnd_total;
  assign offset_int_o = (pipe_i.kind == KIND_ACCEL) ? {rnd_integ[15:1], bit4_q} : rnd_integ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      saved_q <= 1'b0;
    end else if (pipe_i.en && pipe_i.s2_valid) begin
      integ_q <= integ_d;
      if (pipe_i.s2_start) begin
        saved_q <= (pipe_i.kind == KIND_ACCEL) & arg2_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en) begin
      pp_q     <= pp_d;
      ip_q     <= ip_d;
      arg2_q   <= arg_i;
      pp3_q    <= pp_q;
      integ3_q <= integ_d;
      bit3_q   <= saved_q;
      total4_q <= total4_d;
      integ4_q <= integ3_q;
      bit4_q   <= bit3_q;
    end
  end

endmodule

FILE: hdl/imu_offset_pi_calibrator.sv
// Each result passes stage registers 0 to 4 and then the output register.
// Throughput: one item per cycle, unless the output stalls, through a five-register pipeline with
// one multiplier pair per axis; a round end emits a second result, holding input until it is sent on.
// Reset (asynchronous, active low) clears integrals, gains, counters and the
// pipeline; configuration registers return to their documented defaults.
// ----------------------------------------------------------------------------
// IMU offset PI calibrator
// Three-axis PI offset loop with round control and gain decay.
// ----------------------------------------------------------------------------
`include "imu_offset_pi_calibrator_macros.svh"

module imu_offset_pi_calibrator import ioc_pkg::*; #(
  parameter int ROUND_LENGTH = 100
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  ioc_stream_if.sink             in_i,
  ioc_stream_if.source           out_o
);

  localparam int ITER_W = $clog2(ROUND_LENGTH + 1);

  // Configuration registers
  logic              kind_q;
  logic [GAIN_W-1:0] prop_gain_q, int_gain_q;
  logic [14:0]       gravity_q;
  logic [7:0]        round_count_q;

  // Loop state
  logic [GAIN_W-1:0] pg_q, ig_q, pg_d, ig_d;
  logic [ITER_W-1:0] iter_q, iter_d, iter_base, iter_inc;
  logic [7:0]        good_q, good_d, round_q, round_d;
  logic              done_q, done_d;

  // Pipeline
  logic                    en, s0_fire;
  logic                    s0_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic                    s1_start_q, s2_start_q;
  ioc_in_t                 s0_q;
  ioc_tag_t                tag1_d, tag1_q, tag2_q, tag3_q, tag4_q;
  logic                    s0_start, s0_keep;
  logic signed [ARG_W-1:0] raw [3];
  logic signed [ARG_W-1:0] corr [3];
  logic signed [ARG_W-1:0] arg1_q [3];
  logic [15:0]             mag [3];
  logic [ESUM_W-1:0]       esum;
  logic                    good, early, end_round, finished;
  logic [GAIN_W-1:0]       pg1_q, ig1_q;
  ioc_pipe_t               pipe;
  logic signed [15:0]      off_tot [3];
  logic signed [15:0]      off_int [3];

  // Output stage
  ioc_out_t out_q, pend_q, res_a, res_b;
  logic     out_v_q, pend_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q        <= RST_SENSOR_KIND;
      prop_gain_q   <= RST_PROP_GAIN;
      int_gain_q    <= RST_INT_GAIN;
      gravity_q     <= RST_GRAVITY_COUNTS;
      round_count_q <= RST_ROUND_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SENSOR_KIND:    kind_q        <= cfg_wdata_i[0];
        CFG_PROP_GAIN:      prop_gain_q   <= cfg_wdata_i;
        CFG_INT_GAIN:       int_gain_q    <= cfg_wdata_i;
        CFG_GRAVITY_COUNTS: gravity_q     <= cfg_wdata_i[14:0];
        CFG_ROUND_COUNT:    round_count_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together; the pending slot holds it until the second result moves on
  assign en          = !pend_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready  = en;
  assign s0_fire     = en && s0_v_q;

  // Stage 0: corrected readings, error sum and round control
  assign s0_start = (s0_q.operation == OP_START);

  always_comb begin
    raw[0]  = {s0_q.value_x[15], s0_q.value_x};
    raw[1]  = {s0_q.value_y[15], s0_q.value_y};
    raw[2]  = {s0_q.value_z[15], s0_q.value_z};
    corr[0] = raw[0];
    corr[1] = raw[1];
    corr[2] = (kind_q == KIND_ACCEL) ? raw[2] - $signed({2'b00, gravity_q}) : raw[2];
    for (int i = 0; i < 3; i++) begin
      mag[i] = corr[i][ARG_W-1] ? 16'(-corr[i]) : corr[i][15:0];
    end
    esum = {1'b0, mag[0]} + {1'b0, mag[1]} + {1'b0, mag[2]};
  end

  always_comb begin
    iter_base = iter_q;
    if (iter_q == ITER_W'(ROUND_LENGTH - 1) && esum > ESUM_RESTART) begin
      iter_base = '0;
    end
    good   = (kind_q == KIND_GYRO) ? (esum < ESUM_GOOD_GYRO) : (esum < ESUM_GOOD_ACCEL);
    good_d = (good && good_q != GOOD_MAX) ? good_q + 8'd1 : good_q;
    early  = (esum < ESUM_EARLY) && (iter_base > ITER_W'(ITER_EARLY_MIN))
             && (good_d >= GOOD_MIN);
    iter_inc  = iter_base + ITER_W'(1);
    end_round = early || (iter_inc >= ITER_W'(ROUND_LENGTH));
    finished  = ({1'b0, round_q} + 9'd1) >= {1'b0, round_count_q};

    pg_d    = pg_q;
    ig_d    = ig_q;
    iter_d  = iter_q;
    round_d = round_q;
    done_d  = done_q;
    if (s0_start) begin
      pg_d    = prop_gain_q;
      ig_d    = int_gain_q;
      iter_d  = '0;
      good_d  = '0;
      round_d = '0;
      done_d  = 1'b0;
    end else if (done_q) begin
      good_d = good_q;
    end else if (end_round) begin
      // Scale gains to three quarters, truncating
      pg_d    = GAIN_W'(({2'b00, pg_q} + {1'b0, pg_q, 1'b0}) >> 2);
      ig_d    = GAIN_W'(({2'b00, ig_q} + {1'b0, ig_q, 1'b0}) >> 2);
      iter_d  = '0;
      good_d  = '0;
      round_d = round_q + 8'd1;
      done_d  = finished;
    end else begin
      iter_d = iter_inc;
    end

    tag1_d.round_end    = end_round;
    tag1_d.finished     = finished;
    tag1_d.round_number = round_q;
    tag1_d.error_sum    = esum;
  end

  // Drop samples once the session has finished
  assign s0_keep = s0_start || !done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_q    <= '0;
      ig_q    <= '0;
      iter_q  <= '0;
      good_q  <= '0;
      round_q <= '0;
      done_q  <= 1'b0;
    end else if (s0_fire) begin
      pg_q    <= pg_d;
      ig_q    <= ig_d;
      iter_q  <= iter_d;
      good_q  <= good_d;
      round_q <= round_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q     <= 1'b0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      s4_v_q     <= 1'b0;
      s1_start_q <= 1'b0;
      s2_start_q <= 1'b0;
    end else if (en) begin
      s0_v_q     <= in_i.valid;
      s1_v_q     <= s0_v_q && s0_keep;
      s1_start_q <= s0_start;
      s2_v_q     <= s1_v_q;
      s2_start_q <= s1_start_q;
      // Start transactions give no result; they end at the integral stage
      s3_v_q     <= s2_v_q && !s2_start_q;
      s4_v_q     <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q   <= in_i.payload;
      tag1_q <= tag1_d;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      pg1_q  <= pg_q;
      ig1_q  <= ig_q;
      for (int i = 0; i < 3; i++) begin
        arg1_q[i] <= s0_start ? raw[i] : -corr[i];
      end
    end
  end

  assign pipe.en       = en;
  assign pipe.kind     = kind_q;
  assign pipe.s2_valid = s2_v_q;
  assign pipe.s2_start = s2_start_q;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    ioc_axis u_axis (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .pipe_i       (pipe),
      .arg_i        (arg1_q[g]),
      .pgain_i      (pg1_q),
      .igain_i      (ig1_q),
      .offset_o     (off_tot[g]),
      .offset_int_o (off_int[g])
    );
  end

  always_comb begin
    res_a.offset_x     = off_tot[0];
    res_a.offset_y     = off_tot[1];
    res_a.offset_z     = off_tot[2];
    res_a.error_sum    = {1'b0, tag4_q.error_sum};
    res_a.round_end    = 1'b0;
    res_a.finished     = 1'b0;
    res_a.round_number = tag4_q.round_number;
    res_a.last         = !tag4_q.round_end;

    res_b.offset_x     = off_int[0];
    res_b.offset_y     = off_int[1];
    res_b.offset_z     = off_int[2];
    res_b.error_sum    = {1'b0, tag4_q.error_sum};
    res_b.round_end    = 1'b1;
    res_b.finished     = tag4_q.finished;
    res_b.round_number = tag4_q.round_number;
    res_b.last         = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else if (en) begin
      out_v_q  <= s4_v_q;
      pend_v_q <= s4_v_q && tag4_q.round_end;
    end else if (pend_v_q && out_o.ready) begin
      out_v_q  <= 1'b1;
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= res_a;
      pend_q <= res_b;
    end else if (pend_v_q && out_o.ready) begin
      // Advance the integral-only transaction into the output register
      out_q <= pend_q;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;

  `IOC_ASSERT_IMPL(a_pend_behind_first, clk_i, rst_ni, pend_v_q, out_v_q && !out_q.round_end && !out_q.last, "pending result without its first result")
  `IOC_ASSERT_IMPL(a_pend_holds_input, clk_i, rst_ni, pend_v_q, !in_i.ready, "input taken while a second result waits")
  `IOC_ASSERT_NEXT(a_second_follows, clk_i, rst_ni, out_v_q && out_o.ready && !out_q.last, out_v_q && out_q.round_end && out_q.last, "round-end result did not follow")
  `IOC_ASSERT_NEXT(a_start_clears, clk_i, rst_ni, s0_fire && s0_start, !done_q && round_q == 8'd0 && iter_q == '0, "start did not clear round state")

endmodule
